### hdl/trial_division_primality_test_defines.svh
// ----------------------------------------------------------------------------
// Trial division primality test - assertion macros
// Shared concurrent assertion forms, clocked on clk with rst as disable.
// ----------------------------------------------------------------------------
`ifndef TRIAL_DIVISION_PRIMALITY_TEST_DEFINES_SVH
`define TRIAL_DIVISION_PRIMALITY_TEST_DEFINES_SVH

// ante holds at an edge -> cons holds at the same edge
`define TDPT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// ante holds at an edge -> cons holds at the next edge
`define TDPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/tdpt_pkg.sv
// ----------------------------------------------------------------------------
// tdpt_pkg
// Fixed constants of the trial division primality test.
// ----------------------------------------------------------------------------
package tdpt_pkg;

  localparam int SMALLEST_PRIME    = 2;  // below this: not prime
  localparam int FIRST_ODD_DIVISOR = 3;
  localparam int DIVISOR_STEP      = 2;  // odd divisors only

endpackage

### hdl/tdpt_divider.sv
// ----------------------------------------------------------------------------
// tdpt_divider
// Restoring divider, one quotient bit per cycle; done rises after the last
// quotient bit.
// ----------------------------------------------------------------------------
module tdpt_divider #(
  parameter int VALUE_WIDTH = 31
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  logic [VALUE_WIDTH-1:0] divisor,   // held stable while running
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] quotient,
  output logic [VALUE_WIDTH-1:0] remainder
);

  localparam int CW = $clog2(VALUE_WIDTH);

  logic                   active;
  logic [CW-1:0]          count;
  logic [VALUE_WIDTH-1:0] quo;   // dividend bits shift out, quotient bits in
  logic [VALUE_WIDTH-1:0] rem;
  logic [VALUE_WIDTH:0]   trial;
  logic [VALUE_WIDTH:0]   diff;
  logic                   fits;

  assign trial = {rem, quo[VALUE_WIDTH-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      count  <= '0;
      rem    <= '0;
      quo    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        count  <= CW'(VALUE_WIDTH - 1);
        rem    <= '0;
        quo    <= dividend;
      end else if (active) begin
        rem   <= fits ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
        quo   <= {quo[VALUE_WIDTH-2:0], fits};
        count <= count - 1'b1;
        if (count == '0) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

### hdl/trial_division_primality_test.sv
// ----------------------------------------------------------------------------
// trial_division_primality_test
// Reports whether a non-negative integer is prime, by odd trial division.
// ----------------------------------------------------------------------------
// Usage: a transfer in happens at a clock edge with start high and busy low;
// candidate is sampled there. Exactly one result follows: done is high for
// one cycle with is_prime valid, and the receiver cannot stall it, so take it
// in that cycle. Values 0, 1, 2 and even values need no search: done
// comes the cycle right after the transfer and busy never rises. An odd
// candidate of 3 or more raises busy and walks odd divisors 3, 5, 7, ...
// through one shared restoring divider that yields one quotient bit per
// cycle. Each divisor passes through a launch state, a divider load,
// then VALUE_WIDTH divide steps and then the verdict check, and the
// search stops at the first divisor that divides exactly or once the
// quotient falls below the divisor (divisor past the square root). At the
// default width a large prime near 2^31 needs about 23170 divisors.
// busy falls in the same cycle that done is shown, so a new transfer may
// be offered right away.
// ----------------------------------------------------------------------------
module trial_division_primality_test #(
  parameter int VALUE_WIDTH = 31
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [VALUE_WIDTH-1:0] candidate,
  output logic                   done,
  output logic                   is_prime
);

  import tdpt_pkg::*;

  localparam logic [VALUE_WIDTH-1:0] LOW_LIMIT  = VALUE_WIDTH'(SMALLEST_PRIME);
  localparam logic [VALUE_WIDTH-1:0] FIRST_DIV  = VALUE_WIDTH'(FIRST_ODD_DIVISOR);
  localparam logic [VALUE_WIDTH-1:0] STEP       = VALUE_WIDTH'(DIVISOR_STEP);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LAUNCH,   // kick the divider with the current divisor
    S_WAIT      // divider running; judge its result when done
  } state_t;

  state_t                 state;
  logic [VALUE_WIDTH-1:0] held_value;     // candidate under test
  logic [VALUE_WIDTH-1:0] trial_divisor;  // odd divisor being tried
  logic                   div_start;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] div_quotient;
  logic [VALUE_WIDTH-1:0] div_remainder;

  // Shared arithmetic unit: held_value / trial_divisor, one bit per cycle.
  tdpt_divider #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (held_value),
    .divisor   (trial_divisor),
    .done      (div_done),
    .quotient  (div_quotient),
    .remainder (div_remainder)
  );

  // Sequencer. Note: d <= n/d is the same test as d*d <= n, so the quotient
  // the divider already produces bounds the search without a multiplier.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      busy          <= 1'b0;
      done          <= 1'b0;
      is_prime      <= 1'b0;
      div_start     <= 1'b0;
      held_value    <= '0;
      trial_divisor <= '0;
    end else begin
      done      <= 1'b0;
      div_start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            held_value    <= candidate;
            trial_divisor <= FIRST_DIV;
            if (candidate < LOW_LIMIT) begin
              // zero and one: not prime
              done     <= 1'b1;
              is_prime <= 1'b0;
            end else if (candidate == LOW_LIMIT) begin
              // two is the only even prime
              done     <= 1'b1;
              is_prime <= 1'b1;
            end else if (!candidate[0]) begin
              // any other even value is composite
              done     <= 1'b1;
              is_prime <= 1'b0;
            end else begin
              state <= S_LAUNCH;
              busy  <= 1'b1;
            end
          end
        end
        S_LAUNCH: begin
          div_start <= 1'b1;
          state     <= S_WAIT;
        end
        S_WAIT: begin
          if (div_done) begin
            if (div_quotient < trial_divisor) begin
              // divisor is past the square root: no factor exists
              done     <= 1'b1;
              is_prime <= 1'b1;
              busy     <= 1'b0;
              state    <= S_IDLE;
            end else if (div_remainder == '0) begin
              // exact divisor found
              done     <= 1'b1;
              is_prime <= 1'b0;
              busy     <= 1'b0;
              state    <= S_IDLE;
            end else begin
              trial_divisor <= trial_divisor + STEP;
              state         <= S_LAUNCH;
            end
          end
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule

### hdl/tdpt_checker.sv
// ----------------------------------------------------------------------------
// tdpt_checker
// Port-level checks of the primality test, bound to the top level.
// ----------------------------------------------------------------------------
`include "trial_division_primality_test_defines.svh"

module tdpt_checker #(
  parameter int VALUE_WIDTH = 31
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   start,
  input logic                   busy,
  input logic [VALUE_WIDTH-1:0] candidate,
  input logic                   done,
  input logic                   is_prime
);

  import tdpt_pkg::*;

  logic take;
  logic is_small;
  logic is_two;
  logic is_even_big;

  assign take        = start && !busy;
  assign is_small    = candidate < VALUE_WIDTH'(SMALLEST_PRIME);
  assign is_two      = candidate == VALUE_WIDTH'(SMALLEST_PRIME);
  assign is_even_big = !candidate[0] && !is_small && !is_two;

  // after a transfer in: either the search runs or the answer is out
  `TDPT_ASSERT_NEXT(a_take_then_busy_or_done, take, busy ^ done, "neither busy nor done after transfer")
  // zero and one answer not prime at once
  `TDPT_ASSERT_NEXT(a_small_not_prime, take && is_small, done && !is_prime, "0 or 1 misjudged")
  // two answers prime at once
  `TDPT_ASSERT_NEXT(a_two_prime, take && is_two, done && is_prime, "2 misjudged")
  // other even values answer composite at once
  `TDPT_ASSERT_NEXT(a_even_composite, take && is_even_big, done && !is_prime, "even value misjudged")
  // no result without work in flight or a transfer just taken
  `TDPT_ASSERT_SAME(a_done_has_cause, done, $past(busy) || $past(start), "spurious result")

endmodule

bind trial_division_primality_test tdpt_checker #(
  .VALUE_WIDTH (VALUE_WIDTH)
) u_tdpt_checker (.*);

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - trial division primality test bench
// Drives candidates through the start/busy command handshake and checks every
// done strobe against a local trial-division predictor, in transfer order.
// Stimulus: directed corner values first (0, 1, 2, small primes, squares of
// primes, full-width evens and odds, the largest field value), then random
// small values and full-width values that fall quickly to a small factor.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import tdpt_pkg::*;

  localparam int  CAND_W    = 31;
  localparam int  TAIL_CYC  = 40;               // idle tail after the last result
  localparam longint CAND_MAX = (longint'(1) << CAND_W) - 1;
  localparam int  RAND_ITEMS = 81;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              start     = 1'b0;
  logic [CAND_W-1:0] candidate = '0;
  logic              busy;
  logic              done;
  logic              is_prime;

  trial_division_primality_test #(
    .VALUE_WIDTH(CAND_W)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .candidate(candidate),
    .done     (done),
    .is_prime (is_prime)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Items waiting to be offered, and verdicts waiting for their done strobe.
  logic [CAND_W-1:0] pending_candidates[$];
  logic              expected_verdicts[$];
  logic [CAND_W-1:0] expected_inputs[$];      // kept for mismatch reports

  int item_total    = 0;
  int transfers     = 0;
  int results_seen  = 0;
  int primes_seen   = 0;
  int fail_count    = 0;
  int gap_left      = 0;
  bit idle_on       = 1'b1;                   // off during no-idle stretches

  // Trial division over odd divisors up to the square root.
  function automatic logic prime_verdict(logic [CAND_W-1:0] value);
    longint n;
    longint d;
    n = longint'(value);
    if (n < SMALLEST_PRIME) return 1'b0;
    if (n == SMALLEST_PRIME) return 1'b1;
    if (n[0] == 1'b0) return 1'b0;
    for (d = FIRST_ODD_DIVISOR; d * d <= n; d += DIVISOR_STEP) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Idle cycles before the next offer: mostly none or short, a few long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (!idle_on || roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Odd full-width value with an odd factor of at most 31, so the search
  // ends early while the upper bits still get exercised.
  function automatic logic [CAND_W-1:0] odd_with_small_factor();
    longint f;
    longint lim;
    longint r;
    f   = FIRST_ODD_DIVISOR + DIVISOR_STEP * $urandom_range(0, 14);
    lim = CAND_MAX / f;
    r   = 2 * longint'($urandom_range(0, int'((lim - 1) / 2))) + 1;
    return CAND_W'(f * r);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: start stays up until the transfer, then drops for any gap.
  // A transfer happens at an edge with start high and busy low.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    logic took;
    if (rst) begin
      start     <= 1'b0;
      candidate <= '0;
      gap_left  <= 0;
    end else begin
      took = start && !busy;
      if (took) begin
        expected_verdicts.push_back(prime_verdict(candidate));
        expected_inputs.push_back(candidate);
        transfers++;
        if (transfers % 16 == 0) idle_on = ($urandom_range(0, 3) != 0);
      end
      if (start && !took) begin
        // offer stands; hold start and candidate
      end else if (gap_left > 0) begin
        start    <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_candidates.size() > 0) begin
        start     <= 1'b1;
        candidate <= pending_candidates.pop_front();
        gap_left  <= pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: each done strobe is one result, matched to the oldest transfer.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    logic              want;
    logic [CAND_W-1:0] cand;
    if (!rst && done) begin
      results_seen++;
      if (is_prime === 1'b1) primes_seen++;
      if (expected_verdicts.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("[%0t] unexpected result: is_prime=%b with no transfer pending",
                   $realtime, is_prime);
      end else begin
        want = expected_verdicts.pop_front();
        cand = expected_inputs.pop_front();
        if (is_prime !== want) begin
          fail_count++;
          if (fail_count <= 10)
            $display("[%0t] mismatch: candidate=%0d is_prime expected %b got %b",
                     $realtime, cand, want, is_prime);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    int roll;
    int leftover;

    // Directed: below two, two, small primes, squares of primes (divisor
    // exactly at the square root), small odd composites, full-width evens,
    // odd full-width composites, medium primes and the largest field value,
    // which is itself prime and walks the whole divisor range.
    pending_candidates.push_back(CAND_W'(0));
    pending_candidates.push_back(CAND_W'(1));
    pending_candidates.push_back(CAND_W'(2));
    pending_candidates.push_back(CAND_W'(3));
    pending_candidates.push_back(CAND_W'(4));
    pending_candidates.push_back(CAND_W'(5));
    pending_candidates.push_back(CAND_W'(9));
    pending_candidates.push_back(CAND_W'(15));
    pending_candidates.push_back(CAND_W'(25));
    pending_candidates.push_back(CAND_W'(49));
    pending_candidates.push_back(CAND_W'(63001));        // 251 squared
    pending_candidates.push_back(CAND_W'(65521));        // prime below 2^16
    pending_candidates.push_back(CAND_W'(65535));
    pending_candidates.push_back(CAND_W'(1000003));      // prime
    pending_candidates.push_back(CAND_W'(1073741824));   // 2^30
    pending_candidates.push_back(CAND_W'(CAND_MAX - 1)); // largest even
    pending_candidates.push_back(CAND_W'(CAND_MAX - 2)); // odd, factor 5
    pending_candidates.push_back(CAND_W'(CAND_MAX));     // largest, prime
    pending_candidates.push_back(CAND_W'(7));

    // Random: small values carry most primes; full-width evens and odd
    // values with a small factor cover the upper bits at low cost.
    repeat (RAND_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 40)
        pending_candidates.push_back(CAND_W'($urandom_range(0, 4095)));
      else if (roll < 50)
        pending_candidates.push_back(CAND_W'($urandom_range(0, 65535)));
      else if (roll < 75)
        pending_candidates.push_back({(CAND_W - 1)'($urandom), 1'b0});
      else
        pending_candidates.push_back(odd_with_small_factor());
    end
    item_total = pending_candidates.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    wait (transfers == item_total);
    wait (expected_verdicts.size() == 0);
    repeat (TAIL_CYC) @(posedge clk);

    leftover = expected_verdicts.size();
    if (leftover > 0)
      $display("%0d transfers never produced a result", leftover);

    $display("Covered %0d candidates: corner values, the largest 31-bit prime,",
             transfers);
    $display("small random values and quick-falling full-width values; %0d of %0d prime",
             primes_seen, results_seen);
    if (fail_count == 0 && leftover == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d failures", fail_count + leftover);
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: the clock period is 12 ns; a run still going at the timeout fails.
  initial begin
    #(60_000_000);
    $display("timeout: %0d of %0d transfers, %0d results", transfers, item_total,
             results_seen);
    $display("== FAIL ==");
    $finish;
  end

endmodule
